[rtl/core/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// tsw_pkg
// shared widths, constants, register codes and the configuration struct
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int TICK_W = 64;
  localparam int SEC_W  = 64;
  localparam int NSEC_W = 30;
  localparam int RATE_W = 32;
  localparam int DSEC_W = 36;   // whole seconds of a 64-bit nanosecond count
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam int DIV_STEPS_DEF = 4;

  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;

  // 10^9 = 2^9 * 5^9; ceil(2^76 / 5^9) is exact for 55-bit dividends
  localparam logic [55:0] REC_M = 56'd38685626227668134;
  localparam logic [20:0] REC_D = 21'd1953125;

  typedef enum logic [2:0] {
    REG_WALL_SEC  = 3'd0,
    REG_WALL_NSEC = 3'd1,
    REG_REF_TICKS = 3'd2,
    REG_RATE_NS   = 3'd3,
    REG_RATE_TICK = 3'd4
  } reg_idx_t;

  // normalized reference; the user must hold it steady while beats are in flight (not enforced)
  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
    logic [TICK_W-1:0] ticks;
    logic [RATE_W-1:0] num;
    logic [RATE_W-1:0] den;
  } cfg_t;

endpackage

[rtl/core/tsw_if.sv]
// ----------------------------------------------------------------------------
// tsw_in_if / tsw_out_if
// valid/ready channels for tick stamps and wall time results
// ----------------------------------------------------------------------------
interface tsw_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] tick_stamp;

  modport source (output valid, output tick_stamp, input ready);
  modport sink   (input valid, input tick_stamp, output ready);
endinterface

interface tsw_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] out_sec;
  logic        [29:0] out_nsec;

  modport source (output valid, output out_sec, output out_nsec, input ready);
  modport sink   (input valid, input out_sec, input out_nsec, output ready);
endinterface

[rtl/core/tsw_div.sv]
// ----------------------------------------------------------------------------
// tsw_div
// pipelined restoring divider, SPS quotient bits per stage
// ----------------------------------------------------------------------------
module tsw_div #(
  parameter int QW  = 64,
  parameter int DW  = 32,
  parameter int SPS = 4,
  parameter int SBW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [DW-1:0] i_rem,
  input  logic [QW-1:0] i_dvd,
  input  logic [SBW-1:0] i_sb,
  input  logic [DW-1:0] den,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [QW-1:0] o_quo,
  output logic [DW-1:0] o_rem,
  output logic [SBW-1:0] o_sb
);

  localparam int NS = QW / SPS;

  logic           v_r   [NS];
  logic [DW-1:0]  rem_r [NS];
  logic [QW-1:0]  dq_r  [NS];
  logic [SBW-1:0] sb_r  [NS];
  logic           rdy   [NS+1];

  function automatic logic [DW+QW-1:0] div_steps(input logic [DW-1:0] rem,
                                                 input logic [QW-1:0] dq,
                                                 input logic [DW-1:0] d);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [QW-1:0] q;
    logic          b;
    r = rem;
    q = dq;
    for (int j = 0; j < SPS; j++) begin
      t = {r, q[QW-1]};
      b = (t >= {1'b0, d});
      if (b) t = t - {1'b0, d};
      r = t[DW-1:0];
      q = {q[QW-2:0], b};
    end
    return {r, q};
  endfunction

  assign rdy[NS]  = o_ready;
  assign i_ready  = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic           src_v;
    logic [DW-1:0]  src_rem;
    logic [QW-1:0]  src_dq;
    logic [SBW-1:0] src_sb;

    if (k == 0) begin : g_first
      assign src_v   = i_valid;
      assign src_rem = i_rem;
      assign src_dq  = i_dvd;
      assign src_sb  = i_sb;
    end else begin : g_next
      assign src_v   = v_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_dq  = dq_r[k-1];
      assign src_sb  = sb_r[k-1];
    end

    assign rdy[k] = ~v_r[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        {rem_r[k], dq_r[k]} <= div_steps(src_rem, src_dq, den);
        sb_r[k]             <= src_sb;
      end
    end
  end

  assign o_valid = v_r[NS-1];
  assign o_quo   = dq_r[NS-1];
  assign o_rem   = rem_r[NS-1];
  assign o_sb    = sb_r[NS-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_rem < den))
    else $error("divider remainder not below divisor");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_quo))
    else $error("stalled quotient lost");

endmodule

[rtl/core/tsw_scale.sv]
// ----------------------------------------------------------------------------
// tsw_scale
// tick distance and 64x32 product, split into divider words
// ----------------------------------------------------------------------------
module tsw_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  tsw_pkg::cfg_t cfg,
  tsw_in_if.sink        in_beat,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [31:0]   o_rem,
  output logic [63:0]   o_dvd,
  output logic [1:0]    o_sb      // {saturate, older}
);
  import tsw_pkg::*;

  logic              va_r, vb_r, vc_r;
  logic              rdy_a, rdy_b, rdy_c;
  logic              older_a_r, older_b_r;
  logic [TICK_W-1:0] delta_a_r;
  logic [63:0]       lo_b_r, hi_b_r;
  logic [32:0]       mid;
  logic [31:0]       w2;
  logic              older;
  logic [31:0]       rem_r;
  logic [63:0]       dvd_r;
  logic [1:0]        sb_r;

  assign rdy_c = ~vc_r | o_ready;
  assign rdy_b = ~vb_r | rdy_c;
  assign rdy_a = ~va_r | rdy_b;
  assign in_beat.ready = rdy_a;

  assign older = (cfg.ticks >= in_beat.tick_stamp);
  assign mid   = {1'b0, lo_b_r[63:32]} + {1'b0, hi_b_r[31:0]};
  assign w2    = hi_b_r[63:32] + {31'd0, mid[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_beat.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_beat.valid) begin
      older_a_r <= older;
      delta_a_r <= older ? (cfg.ticks - in_beat.tick_stamp)
                         : (in_beat.tick_stamp - cfg.ticks);
    end
    if (rdy_b && va_r) begin
      older_b_r <= older_a_r;
      lo_b_r    <= {32'd0, delta_a_r[31:0]} * {32'd0, cfg.num};
      hi_b_r    <= {32'd0, delta_a_r[63:32]} * {32'd0, cfg.num};
    end
    if (rdy_c && vb_r) begin
      // quotient reaches 2^64 exactly when the top word is not below the divisor
      sb_r  <= {(w2 >= cfg.den), older_b_r};
      rem_r <= (w2 >= cfg.den) ? 32'd0 : w2;
      dvd_r <= {mid[31:0], lo_b_r[31:0]};
    end
  end

  assign o_valid = vc_r;
  assign o_rem   = rem_r;
  assign o_dvd   = dvd_r;
  assign o_sb    = sb_r;

endmodule

[rtl/core/tsw_merge.sv]
// ----------------------------------------------------------------------------
// tsw_merge
// splits the offset by 10^9 and applies it to the reference with carry or borrow
// ----------------------------------------------------------------------------
module tsw_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsw_pkg::cfg_t               cfg,
  input  logic                        i_valid,
  output logic                        i_ready,
  input  logic [63:0]                 i_delta,
  input  logic                        i_older,
  tsw_out_if.source                   out_beat
);
  import tsw_pkg::*;

  logic              vp_r, vs_r, vq_r, vd_r, ve_r;
  logic              rdy_p, rdy_s, rdy_q, rdy_d, rdy_e;
  logic [54:0]       y;
  logic [63:0]       pp00_r;
  logic [55:0]       pp01_r;
  logic [54:0]       pp10_r;
  logic [46:0]       pp11_r, pp11_s_r;
  logic [56:0]       mid_s_r;
  logic [47:0]       top;
  logic [20:0]       ylo_p_r, ylo_s_r, ylo_q_r, ylo_d_r;
  logic [8:0]        low_p_r, low_s_r, low_q_r, low_d_r;
  logic              older_p_r, older_s_r, older_q_r, older_d_r, older_e_r;
  logic [34:0]       q_q_r, q_d_r;
  logic [20:0]       qd_d_r;
  logic [DSEC_W-1:0] dsec_e_r;
  logic [NSEC_W-1:0] dnsec_e_r;

  logic              v1_r, v2_r, rdy1, rdy2;
  logic              older_r, adj_r;
  logic [DSEC_W-1:0] dsec_r;
  logic [NSEC_W-1:0] nsec_r;
  logic [NSEC_W:0]   sum, dif;
  logic              borrow, carry;
  logic [SEC_W-1:0]  sec_r;
  logic [NSEC_W-1:0] nsec_o_r;
  logic [SEC_W-1:0]  dsec_x;

  assign rdy2    = ~v2_r | out_beat.ready;
  assign rdy1    = ~v1_r | rdy2;
  assign rdy_e   = ~ve_r | rdy1;
  assign rdy_d   = ~vd_r | rdy_e;
  assign rdy_q   = ~vq_r | rdy_d;
  assign rdy_s   = ~vs_r | rdy_q;
  assign rdy_p   = ~vp_r | rdy_s;
  assign i_ready = rdy_p;

  // low nine bits pass straight into the nanoseconds, the rest is divided by 5^9
  assign y   = i_delta[63:9];
  assign top = {1'b0, pp11_s_r} + {23'd0, mid_s_r[56:32]};

  assign borrow = (cfg.nsec < dnsec_e_r);
  assign sum    = {1'b0, cfg.nsec} + {1'b0, dnsec_e_r};
  assign carry  = (sum >= {1'b0, NS_PER_SEC});
  assign dif    = borrow ? ({1'b0, cfg.nsec} + {1'b0, NS_PER_SEC} - {1'b0, dnsec_e_r})
                         : ({1'b0, cfg.nsec} - {1'b0, dnsec_e_r});
  assign dsec_x = {{(SEC_W-DSEC_W){1'b0}}, dsec_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vs_r <= 1'b0;
      vq_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy_p) vp_r <= i_valid;
      if (rdy_s) vs_r <= vp_r;
      if (rdy_q) vq_r <= vs_r;
      if (rdy_d) vd_r <= vq_r;
      if (rdy_e) ve_r <= vd_r;
      if (rdy1) v1_r <= ve_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p && i_valid) begin
      pp00_r    <= {32'd0, y[31:0]} * {32'd0, REC_M[31:0]};
      pp01_r    <= {24'd0, y[31:0]} * {32'd0, REC_M[55:32]};
      pp10_r    <= {32'd0, y[54:32]} * {23'd0, REC_M[31:0]};
      pp11_r    <= {24'd0, y[54:32]} * {23'd0, REC_M[55:32]};
      ylo_p_r   <= y[20:0];
      low_p_r   <= i_delta[8:0];
      older_p_r <= i_older;
    end
    if (rdy_s && vp_r) begin
      mid_s_r   <= {1'b0, pp01_r} + {2'b0, pp10_r} + {25'd0, pp00_r[63:32]};
      pp11_s_r  <= pp11_r;
      ylo_s_r   <= ylo_p_r;
      low_s_r   <= low_p_r;
      older_s_r <= older_p_r;
    end
    if (rdy_q && vs_r) begin
      q_q_r     <= top[46:12];
      ylo_q_r   <= ylo_s_r;
      low_q_r   <= low_s_r;
      older_q_r <= older_s_r;
    end
    if (rdy_d && vq_r) begin
      // remainder fits in 21 bits, so only the low bits of q * 5^9 matter
      qd_d_r    <= q_q_r[20:0] * REC_D;
      q_d_r     <= q_q_r;
      ylo_d_r   <= ylo_q_r;
      low_d_r   <= low_q_r;
      older_d_r <= older_q_r;
    end
    if (rdy_e && vd_r) begin
      dsec_e_r  <= {1'b0, q_d_r};
      dnsec_e_r <= {ylo_d_r - qd_d_r, low_d_r};
      older_e_r <= older_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && ve_r) begin
      older_r <= older_e_r;
      dsec_r  <= dsec_e_r;
      if (older_e_r) begin
        adj_r  <= borrow;
        nsec_r <= dif[NSEC_W-1:0];
      end else begin
        adj_r  <= carry;
        nsec_r <= carry ? NSEC_W'(sum - {1'b0, NS_PER_SEC}) : sum[NSEC_W-1:0];
      end
    end
    if (rdy2 && v1_r) begin
      nsec_o_r <= nsec_r;
      sec_r    <= older_r ? (cfg.sec - dsec_x - {{(SEC_W-1){1'b0}}, adj_r})
                          : (cfg.sec + dsec_x + {{(SEC_W-1){1'b0}}, adj_r});
    end
  end

  assign out_beat.valid    = v2_r;
  assign out_beat.out_sec  = sec_r;
  assign out_beat.out_nsec = nsec_o_r;

  a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid |-> (out_beat.out_nsec < NS_PER_SEC))
    else $error("nanoseconds out of range");

endmodule

[rtl/core/tick_stamp_to_wall_time.sv]
// ----------------------------------------------------------------------------
// tick_stamp_to_wall_time
// converts packet tick stamps to wall seconds and nanoseconds
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  in_beat   | in        | tick_stamp[63:0]
//  out_beat  | out       | out_sec[63:0] signed, out_nsec[29:0]
//  apb       | in/out    | ref_wall_sec, ref_wall_nsec, ref_ticks, rate regs
//
//  one beat per cycle while out_beat is not stalled; beats pass through the scale
//  pipeline, the restoring rate divider pipeline and then the merge pipeline
//  rst_n is synchronous; all valid bits clear, rate registers reset to one
//  each stage holds on stall and fills bubbles ahead of a stalled output
// ----------------------------------------------------------------------------
module tick_stamp_to_wall_time #(
  parameter int DIV_STEPS = tsw_pkg::DIV_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tsw_in_if.sink                      in_beat,
  tsw_out_if.source                   out_beat,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [tsw_pkg::DATA_W-1:0]  pwdata,
  output logic [tsw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tsw_pkg::*;

  logic [62:0]       wall_sec_r;
  logic [NSEC_W-1:0] wall_nsec_r;
  logic [TICK_W-1:0] ref_ticks_r;
  logic [RATE_W-1:0] rate_ns_r, rate_tick_r;
  logic [SEC_W-1:0]  norm_sec_r;
  logic [NSEC_W-1:0] norm_nsec_r;
  cfg_t              cfg;
  reg_idx_t          idx;
  logic              wr;

  logic        s_valid, s_ready;
  logic [31:0] s_rem;
  logic [63:0] s_dvd;
  logic [1:0]  s_sb;
  logic        d_valid, d_ready;
  logic [63:0] d_quo, delta;
  logic [31:0] d_rem;
  logic [1:0]  d_sb;

  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_sec_r  <= '0;
      wall_nsec_r <= '0;
      ref_ticks_r <= '0;
      rate_ns_r   <= 32'd1;
      rate_tick_r <= 32'd1;
    end else if (wr) begin
      case (idx)
        REG_WALL_SEC:  wall_sec_r  <= pwdata[62:0];
        REG_WALL_NSEC: wall_nsec_r <= pwdata[NSEC_W-1:0];
        REG_REF_TICKS: ref_ticks_r <= pwdata;
        REG_RATE_NS:   rate_ns_r   <= pwdata[RATE_W-1:0];
        REG_RATE_TICK: rate_tick_r <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WALL_SEC:  prdata = {1'b0, wall_sec_r};
      REG_WALL_NSEC: prdata = {{(DATA_W-NSEC_W){1'b0}}, wall_nsec_r};
      REG_REF_TICKS: prdata = ref_ticks_r;
      REG_RATE_NS:   prdata = {32'd0, rate_ns_r};
      REG_RATE_TICK: prdata = {32'd0, rate_tick_r};
      default:       prdata = '0;
    endcase
  end

  // nanoseconds folded below one second; only used far down the pipe
  always_ff @(posedge clk) begin
    if (wall_nsec_r >= NS_PER_SEC) begin
      norm_nsec_r <= wall_nsec_r - NS_PER_SEC;
      norm_sec_r  <= {1'b0, wall_sec_r} + 64'd1;
    end else begin
      norm_nsec_r <= wall_nsec_r;
      norm_sec_r  <= {1'b0, wall_sec_r};
    end
  end

  // zero rate denominator counts as one
  assign cfg = '{sec:   norm_sec_r,
                 nsec:  norm_nsec_r,
                 ticks: ref_ticks_r,
                 num:   rate_ns_r,
                 den:   (rate_tick_r == '0) ? 32'd1 : rate_tick_r};

  tsw_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_beat (in_beat),
    .o_valid (s_valid),
    .o_ready (s_ready),
    .o_rem   (s_rem),
    .o_dvd   (s_dvd),
    .o_sb    (s_sb)
  );

  tsw_div #(.QW(64), .DW(32), .SPS(DIV_STEPS), .SBW(2)) u_rate_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (s_valid),
    .i_ready (s_ready),
    .i_rem   (s_rem),
    .i_dvd   (s_dvd),
    .i_sb    (s_sb),
    .den     (cfg.den),
    .o_valid (d_valid),
    .o_ready (d_ready),
    .o_quo   (d_quo),
    .o_rem   (d_rem),
    .o_sb    (d_sb)
  );

  // saturated offset is all ones; d_rem is not needed past this point
  assign delta = d_sb[1] ? '1 : d_quo;

  tsw_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .i_valid  (d_valid),
    .i_ready  (d_ready),
    .i_delta  (delta),
    .i_older  (d_sb[0]),
    .out_beat (out_beat)
  );

endmodule
